### design/mca_pkg.sv
// Shared types, constants and helper functions of the motor command arbiter.
package mca_pkg;

   // Number of command sources handled by default.
   localparam int NUM_SOURCES_DEF = 3;

   // Field widths fixed by the command format.
   localparam int SRC_W  = 2;
   localparam int SEQ_W  = 16;
   localparam int OUT_W  = 16;
   localparam int TIME_W = 32;
   localparam int GEN_W  = 32;
   localparam int LIM_W  = 15;
   localparam int MS_W   = 16;

   // Configuration port widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Source codes.
   localparam logic [SRC_W-1:0] SRC_CAN  = 2'd0;
   localparam logic [SRC_W-1:0] SRC_UART = 2'd1;
   localparam logic [SRC_W-1:0] SRC_NONE = 2'd3;

   // Replay window half sizes.
   localparam logic [7:0]  CAN_WINDOW  = 8'd127;
   localparam logic [15:0] WIDE_WINDOW = 16'd32767;

   // Configuration reset values.
   localparam logic [LIM_W-1:0] OUTPUT_LIMIT_RST   = 15'd1000;
   localparam logic [MS_W-1:0]  SESSION_GAP_RST    = 16'd500;
   localparam logic [MS_W-1:0]  LEASE_RST          = 16'd300;
   localparam logic [MS_W-1:0]  STOP_GUARD_RST     = 16'd20;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_LIMIT = 2'd0,
      CSR_SESSION_GAP  = 2'd1,
      CSR_LEASE        = 2'd2,
      CSR_STOP_GUARD   = 2'd3
   } csr_index_type;

   // Event kinds.
   typedef enum logic [1:0] {
      OP_SUBMIT      = 2'd0,
      OP_MODE_CHANGE = 2'd1,
      OP_FAULT       = 2'd2,
      OP_FAILURE     = 2'd3
   } op_type;

   // Result codes.
   typedef enum logic [3:0] {
      RC_ACCEPTED = 4'd0,
      RC_STOP     = 4'd1,
      RC_REPLAY   = 4'd2,
      RC_RANGE    = 4'd3,
      RC_MODE     = 4'd4,
      RC_SAFETY   = 4'd5,
      RC_HANDOFF  = 4'd6,
      RC_BUSY     = 4'd7,
      RC_ERROR    = 4'd8
   } code_type;

   // Stop request kinds.
   typedef enum logic [1:0] {
      STOP_NONE    = 2'd0,
      STOP_USER    = 2'd1,
      STOP_HANDOFF = 2'd2,
      STOP_FAULT   = 2'd3
   } stop_type;

   // Configuration register set.
   typedef struct packed {
      logic [LIM_W-1:0] output_limit;
      logic [MS_W-1:0]  session_gap_ms;
      logic [MS_W-1:0]  lease_ms;
      logic [MS_W-1:0]  stop_guard_ms;
   } cfg_type;

   // One captured request.
   typedef struct packed {
      op_type                  operation;
      logic [SRC_W-1:0]        source;
      logic [SEQ_W-1:0]        sequence_req;
      logic                    enable;
      logic signed [OUT_W-1:0] left_output;
      logic signed [OUT_W-1:0] right_output;
      logic [1:0]              mode;
      logic                    current_mode;
      logic                    power_allowed;
      logic [TIME_W-1:0]       now_ms;
      logic [GEN_W-1:0]        failed_generation;
   } item_type;

   // One result.
   typedef struct packed {
      code_type          result_code;
      stop_type          stop_request;
      logic              forward_command;
      logic              mode_change;
      logic [GEN_W-1:0]  generation_out;
      logic [SRC_W-1:0]  lease_owner;
   } result_type;

   // Ownership, guard and generation state.
   typedef struct packed {
      logic [SRC_W-1:0]  owner;
      logic [TIME_W-1:0] owner_time;
      logic [TIME_W-1:0] guard_start;
      logic              guard_active;
      logic [GEN_W-1:0]  generation;
   } arb_state_type;

   // Replay window entry of one source.
   typedef struct packed {
      logic [SEQ_W-1:0]  last_seq;
      logic [TIME_W-1:0] last_seen_time;
      logic              seq_valid;
   } seq_entry_type;

   // The replay window used by an event: mode changes always use the uart window.
   function automatic logic [SRC_W-1:0] window_source(op_type op, logic [SRC_W-1:0] src);
      return (op == OP_MODE_CHANGE) ? SRC_UART : src;
   endfunction

endpackage

### design/mca_if.sv
// Handshake interfaces of the request, result and configuration channels.
interface mca_req_if
   import mca_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              operation;
   logic [SRC_W-1:0]        source_id;
   logic [SEQ_W-1:0]        sequence_req;
   logic                    enable;
   logic signed [OUT_W-1:0] left_output;
   logic signed [OUT_W-1:0] right_output;
   logic [1:0]              mode;
   logic                    current_mode;
   logic                    power_allowed;
   logic [TIME_W-1:0]       now_ms;
   logic [GEN_W-1:0]        failed_generation;

   modport source (output valid, operation, source_id, sequence_req, enable, left_output,
                   right_output, mode, current_mode, power_allowed, now_ms,
                   failed_generation, input ready);
   modport sink   (input valid, operation, source_id, sequence_req, enable, left_output,
                   right_output, mode, current_mode, power_allowed, now_ms,
                   failed_generation, output ready);
endinterface

interface mca_rsp_if
   import mca_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [3:0]       result_code;
   logic [1:0]       stop_request;
   logic             forward_command;
   logic             mode_change;
   logic [GEN_W-1:0] generation_out;
   logic [SRC_W-1:0] lease_owner;

   modport source (output valid, result_code, stop_request, forward_command, mode_change,
                   generation_out, lease_owner, input ready);
   modport sink   (input valid, result_code, stop_request, forward_command, mode_change,
                   generation_out, lease_owner, output ready);
endinterface

interface mca_csr_if
   import mca_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/mca_seq_check.sv
// Replay window check of one source: says whether a sequence moves the window forward.
module mca_seq_check
   import mca_pkg::*;
(
   input  logic              is_can,
   input  logic [SEQ_W-1:0]  sequence_req,
   input  logic [TIME_W-1:0] now_ms,
   input  logic [MS_W-1:0]   session_gap_ms,
   input  seq_entry_type     entry,
   output logic              seq_forward,
   output seq_entry_type     entry_next
);

   logic [SEQ_W-1:0]  seq_value;
   logic [TIME_W-1:0] silence;
   logic              fresh;
   logic [7:0]        can_delta;
   logic [15:0]       wide_delta;
   logic              in_window;

   // CAN carries an 8-bit sequence, the others a 16-bit one.
   assign seq_value  = is_can ? {8'd0, sequence_req[7:0]} : sequence_req;
   assign silence    = now_ms - entry.last_seen_time;
   assign fresh      = !entry.seq_valid || (silence > {16'd0, session_gap_ms});
   assign can_delta  = seq_value[7:0] - entry.last_seq[7:0];
   assign wide_delta = seq_value - entry.last_seq;
   assign in_window  = is_can ? (can_delta != 8'd0 && can_delta <= CAN_WINDOW)
                              : (wide_delta != 16'd0 && wide_delta <= WIDE_WINDOW);

   // A fresh session or a step forward inside the window is taken.
   always_comb begin
      seq_forward               = fresh || in_window;
      entry_next.seq_valid      = 1'b1;
      entry_next.last_seen_time = now_ms;
      entry_next.last_seq       = seq_forward ? seq_value : entry.last_seq;
   end

endmodule

### design/mca_decide.sv
// Event decision logic: result and next state for one request.
module mca_decide
   import mca_pkg::*;
#(
   parameter int NUM_SOURCES = NUM_SOURCES_DEF
)
(
   input  item_type      item,
   input  cfg_type       cfg,
   input  arb_state_type state,
   input  seq_entry_type seq_entry,
   output result_type    result,
   output arb_state_type state_next,
   output logic          seq_update,
   output seq_entry_type seq_entry_next
);

   logic                     src_ok;
   logic                     seq_fwd;
   logic signed [OUT_W:0]    left_wide;
   logic signed [OUT_W:0]    right_wide;
   logic signed [OUT_W:0]    lim_pos;
   logic signed [OUT_W:0]    lim_neg;
   logic                     out_of_range;
   logic                     motion;
   logic                     source_mode_bad;
   logic [TIME_W-1:0]        owner_age;
   logic                     lease_in_time;
   logic                     lease_live_now;
   logic [TIME_W-1:0]        guard_age;
   logic                     guard_live;
   logic                     take_own;

   // Replay check on the window that the event uses (the uart window for mode changes).
   mca_seq_check u_seq_check (
      .is_can         (window_source(item.operation, item.source) == SRC_CAN),
      .sequence_req   (item.sequence_req),
      .now_ms         (item.now_ms),
      .session_gap_ms (cfg.session_gap_ms),
      .entry          (seq_entry),
      .seq_forward    (seq_fwd),
      .entry_next     (seq_entry_next)
   );

   // Source, range and mode qualifiers.
   assign src_ok       = (item.source != SRC_NONE) && (int'(item.source) < NUM_SOURCES);
   assign left_wide    = {item.left_output[OUT_W-1], item.left_output};
   assign right_wide   = {item.right_output[OUT_W-1], item.right_output};
   assign lim_pos      = signed'({2'b00, cfg.output_limit});
   assign lim_neg      = -lim_pos;
   assign out_of_range = (left_wide < lim_neg) || (left_wide > lim_pos) ||
                         (right_wide < lim_neg) || (right_wide > lim_pos);
   assign motion       = item.enable &&
                         (item.left_output != '0 || item.right_output != '0);
   assign source_mode_bad = (item.source == SRC_CAN && item.mode != 2'd1) ||
                            (item.source == SRC_UART && item.mode != 2'd0);

   // Lease and stop guard timers against the current state.
   assign owner_age      = item.now_ms - state.owner_time;
   assign lease_in_time  = owner_age <= {16'd0, cfg.lease_ms};
   assign lease_live_now = (state.owner != SRC_NONE) && lease_in_time;
   assign guard_age      = item.now_ms - state.guard_start;
   assign guard_live     = state.guard_active && (guard_age < {16'd0, cfg.stop_guard_ms});

   // Event decision.
   always_comb begin
      result.result_code     = RC_ACCEPTED;
      result.stop_request    = STOP_NONE;
      result.forward_command = 1'b0;
      result.mode_change     = 1'b0;
      state_next             = state;
      seq_update             = 1'b0;
      take_own               = 1'b0;

      unique case (item.operation)
         OP_SUBMIT: begin
            priority if (!src_ok) begin
               result.result_code = RC_ERROR;
            end else if (out_of_range) begin
               result.result_code = RC_RANGE;
            end else if (item.mode > 2'd1) begin
               result.result_code = RC_MODE;
            end else if (motion && source_mode_bad) begin
               result.result_code = RC_MODE;
            end else if (motion && (item.current_mode != item.mode[0])) begin
               result.result_code = RC_MODE;
            end else begin
               seq_update = 1'b1;
               priority if (!motion) begin
                  // A stop is executed even when its sequence is a replay.
                  state_next.guard_start  = item.now_ms;
                  state_next.guard_active = 1'b1;
                  state_next.generation   = state.generation + 1'b1;
                  result.stop_request     = STOP_USER;
                  result.result_code      = RC_STOP;
               end else if (!seq_fwd) begin
                  result.result_code = RC_REPLAY;
               end else if (!item.power_allowed) begin
                  result.result_code = RC_SAFETY;
               end else if (state.owner != SRC_NONE && state.owner != item.source &&
                            !lease_live_now) begin
                  // The old owner's lease ran out: hand over with a stop first.
                  state_next.owner        = SRC_NONE;
                  state_next.guard_start  = item.now_ms;
                  state_next.guard_active = 1'b1;
                  state_next.generation   = state.generation + 1'b1;
                  result.stop_request     = STOP_HANDOFF;
                  result.result_code      = RC_HANDOFF;
               end else if (guard_live) begin
                  result.result_code = RC_HANDOFF;
               end else begin
                  // An expired guard is closed when it is looked at.
                  state_next.guard_active = 1'b0;
                  if (state.owner == SRC_NONE || state.owner == item.source) begin
                     take_own               = 1'b1;
                     state_next.owner       = item.source;
                     state_next.owner_time  = item.now_ms;
                     state_next.generation  = state.generation + 1'b1;
                     result.forward_command = 1'b1;
                     result.result_code     = RC_ACCEPTED;
                  end else begin
                     result.result_code = RC_BUSY;
                  end
               end
            end
         end
         OP_MODE_CHANGE: begin
            if (item.mode > 2'd1) begin
               result.result_code = RC_MODE;
            end else begin
               seq_update = 1'b1;
               if (!seq_fwd) begin
                  result.result_code = RC_REPLAY;
               end else begin
                  state_next.owner        = SRC_NONE;
                  state_next.guard_start  = item.now_ms;
                  state_next.guard_active = 1'b1;
                  state_next.generation   = state.generation + 1'b1;
                  result.stop_request     = STOP_USER;
                  result.mode_change      = 1'b1;
               end
            end
         end
         OP_FAULT, OP_FAILURE: begin
            // A failure only counts when it names the present generation.
            if (src_ok && state.owner == item.source &&
                (item.operation == OP_FAULT ||
                 state.generation == item.failed_generation)) begin
               state_next.owner        = SRC_NONE;
               state_next.guard_start  = item.now_ms;
               state_next.guard_active = 1'b1;
               state_next.generation   = state.generation + 1'b1;
               result.stop_request     = STOP_FAULT;
            end
         end
         default: begin
            result.result_code = RC_ACCEPTED;
         end
      endcase

      // Reported generation and lease owner follow the updated state.
      result.generation_out = state_next.generation;
      result.lease_owner    = (state_next.owner != SRC_NONE && (take_own || lease_in_time))
                              ? state_next.owner : SRC_NONE;
   end

endmodule

### design/motor_command_arbiter_top.sv
// Motor command arbiter: request register, decision logic, state and result register.
// A request is captured in the request register, decided, and its result is held in the result register.
// Throughput: one request per cycle while the result channel is ready; the decision is one registered pass.
// The result register and the request register are parted, so a stalled result
// holds one request and still lets the request channel fill the request register.
// Reset clears ownership, guard and generation state and the replay valid bits, and restores the
// configuration registers to their defaults.
module motor_command_arbiter_top
   import mca_pkg::*;
#(
   parameter int NUM_SOURCES = NUM_SOURCES_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   mca_req_if.sink   req_chan,
   mca_rsp_if.source rsp_chan,
   mca_csr_if.sink   csr_chan
);

   localparam int SIdxW = (NUM_SOURCES > 2) ? $clog2(NUM_SOURCES) : 1;

   cfg_type       cfg_ff;
   logic          in_valid_ff;
   item_type      item_ff;
   logic          rsp_valid_ff;
   result_type    rsp_ff;
   arb_state_type state_ff;
   arb_state_type state_in;
   logic [SEQ_W-1:0]  last_seq_ff       [NUM_SOURCES];
   logic [TIME_W-1:0] last_seen_time_ff [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] seq_valid_ff;

   logic              req_accept;
   logic              advance;
   logic [SRC_W-1:0]  win_src;
   logic [SIdxW-1:0]  win_idx;
   logic              win_in_range;
   seq_entry_type     seq_entry;
   seq_entry_type     seq_entry_in;
   logic              seq_update;
   result_type        result_in;

   // Handshakes: the request register moves on whenever the result register is free.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_limit   <= OUTPUT_LIMIT_RST;
         cfg_ff.session_gap_ms <= SESSION_GAP_RST;
         cfg_ff.lease_ms       <= LEASE_RST;
         cfg_ff.stop_guard_ms  <= STOP_GUARD_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_OUTPUT_LIMIT: cfg_ff.output_limit   <= csr_chan.data[LIM_W-1:0];
            CSR_SESSION_GAP:  cfg_ff.session_gap_ms <= csr_chan.data;
            CSR_LEASE:        cfg_ff.lease_ms       <= csr_chan.data;
            CSR_STOP_GUARD:   cfg_ff.stop_guard_ms  <= csr_chan.data;
            default:          cfg_ff.output_limit   <= cfg_ff.output_limit;
         endcase
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.operation         <= op_type'(req_chan.operation);
         item_ff.source            <= req_chan.source_id;
         item_ff.sequence_req      <= req_chan.sequence_req;
         item_ff.enable            <= req_chan.enable;
         item_ff.left_output       <= req_chan.left_output;
         item_ff.right_output      <= req_chan.right_output;
         item_ff.mode              <= req_chan.mode;
         item_ff.current_mode      <= req_chan.current_mode;
         item_ff.power_allowed     <= req_chan.power_allowed;
         item_ff.now_ms            <= req_chan.now_ms;
         item_ff.failed_generation <= req_chan.failed_generation;
      end
   end

   // Replay window read for the source whose window this request uses.
   assign win_src      = window_source(item_ff.operation, item_ff.source);
   assign win_idx      = SIdxW'(win_src);
   assign win_in_range = int'(win_src) < NUM_SOURCES;

   always_comb begin
      if (win_in_range) begin
         seq_entry.last_seq       = last_seq_ff[win_idx];
         seq_entry.last_seen_time = last_seen_time_ff[win_idx];
         seq_entry.seq_valid      = seq_valid_ff[win_idx];
      end else begin
         seq_entry = '0;
      end
   end

   // Decision for the request held in the request register.
   mca_decide #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_decide (
      .item           (item_ff),
      .cfg            (cfg_ff),
      .state          (state_ff),
      .seq_entry      (seq_entry),
      .result         (result_in),
      .state_next     (state_in),
      .seq_update     (seq_update),
      .seq_entry_next (seq_entry_in)
   );

   // Arbitration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.owner        <= SRC_NONE;
         state_ff.owner_time   <= '0;
         state_ff.guard_start  <= '0;
         state_ff.guard_active <= 1'b0;
         state_ff.generation   <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Replay windows: valid bits are cleared by reset, entries are written on use.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= '0;
      end else if (advance && seq_update && win_in_range) begin
         seq_valid_ff[win_idx] <= seq_entry_in.seq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && seq_update && win_in_range) begin
         last_seq_ff[win_idx]       <= seq_entry_in.last_seq;
         last_seen_time_ff[win_idx] <= seq_entry_in.last_seen_time;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.result_code     = rsp_ff.result_code;
   assign rsp_chan.stop_request    = rsp_ff.stop_request;
   assign rsp_chan.forward_command = rsp_ff.forward_command;
   assign rsp_chan.mode_change     = rsp_ff.mode_change;
   assign rsp_chan.generation_out  = rsp_ff.generation_out;
   assign rsp_chan.lease_owner     = rsp_ff.lease_owner;

   // The generation moves by at most one per request and only when a request completes.
   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (state_ff.generation == $past(state_ff.generation)) ||
                  (state_ff.generation == $past(state_ff.generation) + 1'b1))
      else $error("generation moved by more than one step");

   a_gen_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff.generation))
      else $error("generation changed without a request");

   // A forwarded command leaves an owner in place.
   a_fwd_owner: assert property (@(posedge clock) disable iff (reset)
      advance && result_in.forward_command |=> state_ff.owner != SRC_NONE)
      else $error("forwarded command without an owner");

   // A mode change always opens the stop guard and drops the owner.
   a_mode_guard: assert property (@(posedge clock) disable iff (reset)
      advance && result_in.mode_change |=> state_ff.guard_active &&
                                           state_ff.owner == SRC_NONE)
      else $error("mode change did not stop the motors");

endmodule
